### sv/irbb_pkg.sv
// Shared types and constants for the backward image rotation block.
// No dependencies; irbb_coord, irbb_blend, the top level and the bench import it.
package irbb_pkg;

  // Trigonometric values are signed Q1.14
  localparam int unsigned TRIG_BITS = 14;
  localparam int unsigned CFG_DW    = 20;
  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned PIX_W     = 24;

  typedef enum logic [CFG_IW-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_OFF_R  = 3'd2,
    REG_OFF_C  = 3'd3,
    REG_HEIGHT = 3'd4,
    REG_WIDTH  = 3'd5
  } irbb_reg_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } irbb_op_e;

  // Per-stage control flags that travel with an item
  typedef struct packed {
    logic vld;
    logic cmp;
    logic in_win;
    logic inrng;
  } irbb_ctl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       in_win;
  } irbb_res_t;

endpackage

### sv/irbb_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on nothing but the signals declared here.
interface irbb_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [9:0] row;
  logic [9:0] col;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;
  modport source (output valid, opcode, row, col, blue_in, green_in, red_in, input ready);
  modport sink (input valid, opcode, row, col, blue_in, green_in, red_in, output ready);
endinterface

interface irbb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       inside_res;
  modport source (output valid, blue_out, green_out, red_out, inside_res, input ready);
  modport sink (input valid, blue_out, green_out, red_out, inside_res, output ready);
endinterface

### sv/irbb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module irbb_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/irbb_coord.sv
// Coordinate pipeline: offset subtract, rotation multiply, floor shift, window test.
// Depends on irbb_pkg.
module irbb_coord import irbb_pkg::*; #(
  parameter int unsigned MAX_DIM       = 512,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        acc,
  input  logic                        opcode,
  input  logic [9:0]                  row,
  input  logic [9:0]                  col,
  input  logic [PIX_W-1:0]            pix,
  input  logic signed [15:0]          cos_a,
  input  logic signed [15:0]          sin_a,
  input  logic signed [19:0]          off_r,
  input  logic signed [19:0]          off_c,
  input  logic [9:0]                  height,
  input  logic [9:0]                  width,
  output irbb_ctl_t                   ctl3,
  output logic [$clog2(MAX_DIM)-1:0]  xi,
  output logic [$clog2(MAX_DIM)-1:0]  yi,
  output logic [FRACTION_BITS-1:0]    fx,
  output logic [FRACTION_BITS-1:0]    fy,
  output logic [$clog2(MAX_DIM)-1:0]  ld_row,
  output logic [$clog2(MAX_DIM)-1:0]  ld_col,
  output logic [PIX_W-1:0]            ld_pix
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned RW = ((10 + F > 19) ? 10 + F : 19) + 2;
  localparam int unsigned PW = RW + 16;
  localparam int unsigned SW = PW + 1;

  irbb_ctl_t               ctl1_r, ctl2_r, ctl3_r;
  logic signed [RW-1:0]    br_r, bc_r;
  logic signed [PW-1:0]    p_cr_r, p_sc_r, p_cc_r, p_sr_r;
  logic [9:0]              row1_r, col1_r, row2_r, col2_r;
  logic [PIX_W-1:0]        pix1_r, pix2_r, pix3_r;
  logic [AW-1:0]           xi_r, yi_r, row3_r, col3_r;
  logic [F-1:0]            fx_r, fy_r;
  logic signed [RW-1:0]    row_fx, col_fx;
  logic signed [SW-1:0]    sum_r, sum_c, sr, sc, lim_h, lim_w;
  logic [11:0]             hgt, wid;
  logic                    inrng, in_win;

  // Scale input coordinates and check the load range
  assign row_fx = $signed({{(RW-10-F){1'b0}}, row, {F{1'b0}}});
  assign col_fx = $signed({{(RW-10-F){1'b0}}, col, {F{1'b0}}});
  assign inrng  = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);

  // Saturate dimensions and form the fixed-point window limits
  assign hgt   = (32'(height) > MAX_DIM) ? 12'(MAX_DIM) : 12'(height);
  assign wid   = (32'(width) > MAX_DIM) ? 12'(MAX_DIM) : 12'(width);
  assign lim_h = SW'($signed({1'b0, hgt}) - 13'sd1) <<< F;
  assign lim_w = SW'($signed({1'b0, wid}) - 13'sd1) <<< F;

  // Rotate: sums of products, floored by the arithmetic shift
  assign sum_r  = SW'(p_cr_r) + SW'(p_sc_r);
  assign sum_c  = SW'(p_cc_r) - SW'(p_sr_r);
  assign sr     = sum_r >>> TRIG_BITS;
  assign sc     = sum_c >>> TRIG_BITS;
  assign in_win = (sr > 0) && (sc > 0) && (sr < lim_h) && (sc < lim_w);

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= '{vld: acc, cmp: (opcode == OP_COMPUTE), in_win: 1'b0, inrng: inrng};
      ctl2_r <= ctl1_r;
      ctl3_r <= '{vld: ctl2_r.vld, cmp: ctl2_r.cmp, in_win: in_win, inrng: ctl2_r.inrng};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      br_r   <= row_fx - RW'(off_r);
      bc_r   <= col_fx - RW'(off_c);
      row1_r <= row;
      col1_r <= col;
      pix1_r <= pix;
      p_cr_r <= cos_a * br_r;
      p_sc_r <= sin_a * bc_r;
      p_cc_r <= cos_a * bc_r;
      p_sr_r <= sin_a * br_r;
      row2_r <= row1_r;
      col2_r <= col1_r;
      pix2_r <= pix1_r;
      xi_r   <= sr[F +: AW];
      yi_r   <= sc[F +: AW];
      fx_r   <= sr[F-1:0];
      fy_r   <= sc[F-1:0];
      row3_r <= AW'(row2_r);
      col3_r <= AW'(col2_r);
      pix3_r <= pix2_r;
    end
  end

  assign ctl3   = ctl3_r;
  assign xi     = xi_r;
  assign yi     = yi_r;
  assign fx     = fx_r;
  assign fy     = fy_r;
  assign ld_row = row3_r;
  assign ld_col = col3_r;
  assign ld_pix = pix3_r;

endmodule

### sv/irbb_blend.sv
// Bilinear blend: weights, per-channel products, sum and truncate.
// Depends on irbb_pkg; takes the four bank read beats from the frame store.
module irbb_blend import irbb_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  irbb_ctl_t                ctl3,
  input  logic                     xpar,
  input  logic                     ypar,
  input  logic [FRACTION_BITS-1:0] fx,
  input  logic [FRACTION_BITS-1:0] fy,
  input  logic [PIX_W-1:0]         rdata [4],
  output logic                     res_vld,
  output irbb_res_t                res
);

  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned WW = 2 * F + 1;
  localparam int unsigned MW = WW + 8;
  localparam int unsigned AW = MW + 2;

  irbb_ctl_t        ctl4_r, ctl5_r, ctl6_r;
  logic [WW-1:0]    w_r [4];
  logic             xp_r, yp_r;
  logic [MW-1:0]    m_r [3][4];
  logic [F:0]       gx, gy;
  logic [PIX_W-1:0] p [4];
  logic [AW-1:0]    acc [3];
  irbb_res_t        res_r;

  assign gx = (F+1)'(1 << F) - (F+1)'(fx);
  assign gy = (F+1)'(1 << F) - (F+1)'(fy);

  // Pick each neighbor from its bank by row and column parity
  assign p[0] = rdata[{xp_r, yp_r}];
  assign p[1] = rdata[{~xp_r, yp_r}];
  assign p[2] = rdata[{xp_r, ~yp_r}];
  assign p[3] = rdata[{~xp_r, ~yp_r}];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = AW'(m_r[k][0]) + AW'(m_r[k][1]) + AW'(m_r[k][2]) + AW'(m_r[k][3]);
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      ctl4_r <= ctl3;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  // Weights, products, then sum and truncate
  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= WW'(gy * gx);
      w_r[1] <= WW'(gy * (F+1)'(fx));
      w_r[2] <= WW'((F+1)'(fy) * gx);
      w_r[3] <= WW'((F+1)'(fy) * (F+1)'(fx));
      xp_r   <= xpar;
      yp_r   <= ypar;
      for (int k = 0; k < 3; k++) begin
        for (int n = 0; n < 4; n++) begin
          m_r[k][n] <= w_r[n] * MW'(p[n][8*k +: 8]);
        end
      end
      res_r.blue   <= ctl5_r.in_win ? acc[0][2*F +: 8] : 8'd0;
      res_r.green  <= ctl5_r.in_win ? acc[1][2*F +: 8] : 8'd0;
      res_r.red    <= ctl5_r.in_win ? acc[2][2*F +: 8] : 8'd0;
      res_r.in_win <= ctl5_r.in_win;
    end
  end

  assign res_vld = ctl6_r.vld && ctl6_r.cmp;
  assign res     = res_r;

endmodule

### sv/image_rotate_backward_bilinear.sv
// Backward-mapping image rotation with bilinear interpolation.
// Depends on irbb_pkg, irbb_if, irbb_ram, irbb_coord and irbb_blend.
//
// Channels: in_bus carries load beats (opcode load: write one BGR pixel at
// row, col) and compute beats (opcode compute: output row, col). Each
// compute beat gives one out_bus beat; a load beat gives none.
// Configuration: cfg_we writes cfg_data into register cfg_idx (cosine,
// sine, row and column offsets, source height and width); the user must
// write only while idle, which the block itself does not enforce.
// Throughput: one beat per cycle while the skid entry is empty, loads and
// computes mixed freely. The frame store is split into four banks by row
// and column parity, so the four neighbors of a pixel are read together
// from four RAM ports.
// Loads write the store at the same stage where computes read it, so a
// pixel loaded by an earlier beat is always seen by a later compute.
// Stall: a two-entry output stage (output register plus skid) keeps
// in_bus ready while one result waits; ready drops only when both are full.
// Reset clears control and presets the configuration; the store keeps no
// reset value and needs no clearing pass. MAX_DIM must be a power of two, at least 4.
module image_rotate_backward_bilinear import irbb_pkg::*; #(
  parameter int unsigned MAX_DIM       = 512,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  irbb_in_if.sink            in_bus,
  irbb_out_if.source         out_bus,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_idx,
  input  logic [CFG_DW-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_DIM);
  localparam int unsigned BD = (MAX_DIM / 2) * (MAX_DIM / 2);
  localparam int unsigned BA = 2 * (AW - 1);

  logic signed [15:0] cos_r, sin_r;
  logic signed [19:0] off_r_r, off_c_r;
  logic [9:0]         hgt_r, wid_r;

  logic               en, acc;
  irbb_ctl_t          ctl3;
  logic [AW-1:0]      xi, yi, xi1, yi1, ld_row, ld_col;
  logic [FRACTION_BITS-1:0] fx, fy;
  logic [PIX_W-1:0]   ld_pix;
  logic [PIX_W-1:0]   rdata [4];
  logic               res_vld;
  irbb_res_t          res;

  logic               out_vld_r, out_vld_nxt, sk_vld_r, sk_vld_nxt;
  irbb_res_t          out_res_r, out_res_nxt, sk_res_r, sk_res_nxt;
  logic               push;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= 16'sd16384;
      sin_r   <= '0;
      off_r_r <= '0;
      off_c_r <= '0;
      hgt_r   <= 10'd512;
      wid_r   <= 10'd512;
    end else if (cfg_we) begin
      case (irbb_reg_e'(cfg_idx))
        REG_COS:    cos_r   <= cfg_data[15:0];
        REG_SIN:    sin_r   <= cfg_data[15:0];
        REG_OFF_R:  off_r_r <= cfg_data;
        REG_OFF_C:  off_c_r <= cfg_data;
        REG_HEIGHT: hgt_r   <= cfg_data[9:0];
        REG_WIDTH:  wid_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless the skid entry is occupied
  assign en           = !sk_vld_r;
  assign in_bus.ready = en;
  assign acc          = in_bus.valid && en;

  irbb_coord #(.MAX_DIM(MAX_DIM), .FRACTION_BITS(FRACTION_BITS)) u_coord (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .acc    (acc),
    .opcode (in_bus.opcode),
    .row    (in_bus.row),
    .col    (in_bus.col),
    .pix    ({in_bus.red_in, in_bus.green_in, in_bus.blue_in}),
    .cos_a  (cos_r),
    .sin_a  (sin_r),
    .off_r  (off_r_r),
    .off_c  (off_c_r),
    .height (hgt_r),
    .width  (wid_r),
    .ctl3   (ctl3),
    .xi     (xi),
    .yi     (yi),
    .fx     (fx),
    .fy     (fy),
    .ld_row (ld_row),
    .ld_col (ld_col),
    .ld_pix (ld_pix)
  );

  // Even neighbor index sits at (i+1)>>1, odd at i>>1
  assign xi1 = xi + AW'(1);
  assign yi1 = yi + AW'(1);

  // Frame store banks: bank {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic [1:0] BSEL = 2'(b);
    logic          we;
    logic [BA-1:0] raddr;
    assign we    = en && ctl3.vld && !ctl3.cmp && ctl3.inrng &&
                   (ld_row[0] == BSEL[1]) && (ld_col[0] == BSEL[0]);
    assign raddr = {(BSEL[1] ? xi[AW-1:1] : xi1[AW-1:1]),
                    (BSEL[0] ? yi[AW-1:1] : yi1[AW-1:1])};
    irbb_ram #(.WIDTH(PIX_W), .DEPTH(BD)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr ({ld_row[AW-1:1], ld_col[AW-1:1]}),
      .wdata (ld_pix),
      .re    (en),
      .raddr (raddr),
      .rdata (rdata[b])
    );
  end

  irbb_blend #(.FRACTION_BITS(FRACTION_BITS)) u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl3    (ctl3),
    .xpar    (xi[0]),
    .ypar    (yi[0]),
    .fx      (fx),
    .fy      (fy),
    .rdata   (rdata),
    .res_vld (res_vld),
    .res     (res)
  );

  // Output register and skid: hold while stalled, drain skid first
  assign push = en && res_vld;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    sk_vld_nxt  = sk_vld_r;
    sk_res_nxt  = sk_res_r;
    if (out_vld_r && !out_bus.ready) begin
      if (push) begin
        sk_vld_nxt = 1'b1;
        sk_res_nxt = res;
      end
    end else if (sk_vld_r) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = sk_res_r;
      sk_vld_nxt  = 1'b0;
    end else begin
      out_vld_nxt = push;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    sk_res_r  <= sk_res_nxt;
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.blue_out   = out_res_r.blue;
  assign out_bus.green_out  = out_res_r.green;
  assign out_bus.red_out    = out_res_r.red;
  assign out_bus.inside_res = out_res_r.in_win;

endmodule

### sv/irbb_chk.sv
// Port-level checker for the rotation block, bound to the top level.
// Depends only on the top-level port signals.
module irbb_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] blue_out,
  input logic [7:0] green_out,
  input logic [7:0] red_out,
  input logic       inside_res
);

  // A stalled result beat stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Outside results carry zero color
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !inside_res |-> blue_out == 8'd0 && green_out == 8'd0 && red_out == 8'd0)
    else $error("outside result with nonzero color");

  // Input backpressure only when a result is waiting
  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  // No result right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind image_rotate_backward_bilinear irbb_chk u_irbb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_bus.ready),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .blue_out   (out_bus.blue_out),
  .green_out  (out_bus.green_out),
  .red_out    (out_bus.red_out),
  .inside_res (out_bus.inside_res)
);

### tb/tb_image_rotate_backward_bilinear.sv
// Self-checking bench for the backward rotation block with bilinear blend.
// Depends on irbb_pkg, irbb_if and the block; predicts results in-line.
module tb_image_rotate_backward_bilinear;
  import irbb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM  = 512;
  localparam int FB   = 8;
  localparam int LIMIT = 20000;

  typedef struct packed {
    irbb_op_e   op;
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } beat_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  irbb_in_if  in_bus();
  irbb_out_if out_bus();

  image_rotate_backward_bilinear i_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Shadow state of the predictor
  logic [23:0] pix_store [0:DIM*DIM-1];
  bit          pix_written [0:DIM*DIM-1];
  logic signed [15:0] m_cos, m_sin;
  logic signed [19:0] m_offr, m_offc;
  logic [9:0] m_h, m_w;

  beat_t      pending_beats[$];
  irbb_res_t  expected_pixels[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  rx_hold_left = 0;
  bit  tx_taken = 0;
  bit  rx_taken = 0;
  bit  bench_done = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Predict one beat; loads update the shadow store
  function automatic void rotate_predict(beat_t bt);
    longint h, w, br, bc, sr, sc, acc;
    longint xi, yi, fx, fy, gx, gy;
    logic [23:0] p00, p10, p01, p11;
    irbb_res_t res;
    if (bt.op == OP_LOAD) begin
      if (bt.row < DIM && bt.col < DIM) begin
        pix_store[bt.row*DIM+bt.col] = {bt.r, bt.g, bt.b};
        pix_written[bt.row*DIM+bt.col] = 1;
      end
      return;
    end
    h = (m_h > DIM) ? DIM : m_h;
    w = (m_w > DIM) ? DIM : m_w;
    br = (longint'(bt.row) <<< FB) - longint'(m_offr);
    bc = (longint'(bt.col) <<< FB) - longint'(m_offc);
    sr = (longint'(m_cos) * br + longint'(m_sin) * bc) >>> TRIG_BITS;
    sc = (longint'(m_cos) * bc - longint'(m_sin) * br) >>> TRIG_BITS;
    res = '0;
    if (sr > 0 && sc > 0 && sr < (h - 1) * (1 << FB) && sc < (w - 1) * (1 << FB)) begin
      xi = sr >>> FB; yi = sc >>> FB;
      fx = sr & ((1 << FB) - 1); fy = sc & ((1 << FB) - 1);
      gx = (1 << FB) - fx; gy = (1 << FB) - fy;
      p00 = pix_store[xi*DIM+yi];
      p10 = pix_store[(xi+1)*DIM+yi];
      p01 = pix_store[xi*DIM+yi+1];
      p11 = pix_store[(xi+1)*DIM+yi+1];
      for (int k = 0; k < 3; k++) begin
        acc = gy*gx*p00[8*k+:8] + gy*fx*p10[8*k+:8] + fy*gx*p01[8*k+:8] + fy*fx*p11[8*k+:8];
        case (k)
          0: res.blue  = acc >> (2*FB);
          1: res.green = acc >> (2*FB);
          default: res.red = acc >> (2*FB);
        endcase
      end
      res.in_win = 1;
    end
    expected_pixels.push_back(res);
  endfunction

  // Check that a compute beat reads only loaded entries
  function automatic bit reads_loaded(beat_t bt);
    longint h, w, br, bc, sr, sc, xi, yi;
    if (bt.op == OP_LOAD) return 1;
    h = (m_h > DIM) ? DIM : m_h;
    w = (m_w > DIM) ? DIM : m_w;
    br = (longint'(bt.row) <<< FB) - longint'(m_offr);
    bc = (longint'(bt.col) <<< FB) - longint'(m_offc);
    sr = (longint'(m_cos) * br + longint'(m_sin) * bc) >>> TRIG_BITS;
    sc = (longint'(m_cos) * bc - longint'(m_sin) * br) >>> TRIG_BITS;
    if (!(sr > 0 && sc > 0 && sr < (h - 1) * (1 << FB) && sc < (w - 1) * (1 << FB)))
      return 1;
    xi = sr >>> FB; yi = sc >>> FB;
    return pix_written[xi*DIM+yi] && pix_written[(xi+1)*DIM+yi] &&
           pix_written[xi*DIM+yi+1] && pix_written[(xi+1)*DIM+yi+1];
  endfunction

  // Driver: present pending beats with random gaps
  int tx_gap = 0;
  initial begin
    in_bus.valid = 0; in_bus.opcode = 0; in_bus.row = 0; in_bus.col = 0;
    in_bus.blue_in = 0; in_bus.green_in = 0; in_bus.red_in = 0;
  end
  always @(negedge clk) begin
    if (rst_n) begin
      if (tx_taken) begin
        void'(pending_beats.pop_front());
        tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0) tx_gap = 0;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        in_bus.valid <= 0;
      end else if (pending_beats.size() > 0) begin
        in_bus.valid    <= 1;
        in_bus.opcode   <= pending_beats[0].op;
        in_bus.row      <= pending_beats[0].row;
        in_bus.col      <= pending_beats[0].col;
        in_bus.blue_in  <= pending_beats[0].b;
        in_bus.green_in <= pending_beats[0].g;
        in_bus.red_in   <= pending_beats[0].r;
      end else begin
        in_bus.valid <= 0;
      end
    end
  end

  // Receiver ready with random stalls; rx_hold_left forces a long hold-off
  int rx_gap = 0;
  initial out_bus.ready = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_taken) rx_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 19);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_bus.ready <= 0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_bus.ready <= 0;
      end else out_bus.ready <= 1;
    end
  end

  // Monitor: predict on input beats, compare on output beats
  always @(posedge clk) begin
    irbb_res_t exp_res;
    tx_taken = rst_n && in_bus.valid && in_bus.ready;
    rx_taken = rst_n && out_bus.valid && out_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) rotate_predict(pending_beats[0]);
      if (out_bus.valid && out_bus.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          exp_res = expected_pixels.pop_front();
          if (out_bus.blue_out !== exp_res.blue) begin
            $error("blue_out exp %0d got %0d", exp_res.blue, out_bus.blue_out); errors++;
          end
          if (out_bus.green_out !== exp_res.green) begin
            $error("green_out exp %0d got %0d", exp_res.green, out_bus.green_out); errors++;
          end
          if (out_bus.red_out !== exp_res.red) begin
            $error("red_out exp %0d got %0d", exp_res.red, out_bus.red_out); errors++;
          end
          if (out_bus.inside_res !== exp_res.in_win) begin
            $error("inside_res exp %0d got %0d", exp_res.in_win, out_bus.inside_res); errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n ||
        bench_done)
      idle_cycles <= 0;
    else if (pending_beats.size() > 0 || expected_pixels.size() > 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("tb_image_rotate_backward_bilinear: FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(irbb_reg_e idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_COS:   m_cos  = val[15:0];
      REG_SIN:   m_sin  = val[15:0];
      REG_OFF_R: m_offr = val[19:0];
      REG_OFF_C: m_offc = val[19:0];
      REG_HEIGHT: m_h   = val[9:0];
      default:   m_w    = val[9:0];
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || expected_pixels.size() > 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic queue_load(int r, int c);
    beat_t bt;
    bt.op = OP_LOAD; bt.row = 10'(r); bt.col = 10'(c);
    bt.b = 8'($urandom); bt.g = 8'($urandom); bt.r = 8'($urandom);
    pending_beats.push_back(bt);
    // predictor tracks coverage early so computes in the same phase stay legal
    pix_written[(r%1024 < DIM && c%1024 < DIM) ? (r*DIM+c) : 0] |=
      (r < DIM && c < DIM);
  endtask

  // Queue a compute only when every neighbor it reads has been loaded
  task automatic queue_compute(int r, int c);
    beat_t bt;
    bt = '0; bt.op = OP_COMPUTE; bt.row = 10'(r); bt.col = 10'(c);
    bt.b = 8'($urandom); bt.g = 8'($urandom); bt.r = 8'($urandom);
    if (reads_loaded(bt)) pending_beats.push_back(bt);
  endtask

  initial begin
    m_cos = 16384; m_sin = 0; m_offr = 0; m_offc = 0; m_h = 512; m_w = 512;
    foreach (pix_written[i]) pix_written[i] = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;

    // Load a 16x16 patch fully, plus the far store corner and out-of-store loads
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) queue_load(r, c);
    for (int r = 510; r < 512; r++)
      for (int c = 510; c < 512; c++) queue_load(r, c);
    queue_load(1023, 5); queue_load(5, 1023); queue_load(512, 512);
    drain();

    // Directed: identity at edges of the window, far corner, max fields
    write_reg(REG_HEIGHT, 16); write_reg(REG_WIDTH, 16);
    queue_compute(0, 5); queue_compute(5, 0); queue_compute(1, 1);
    queue_compute(14, 14); queue_compute(15, 5); queue_compute(1023, 1023);
    queue_compute(10, 11);
    drain();
    // Dimension above store and degenerate dimensions
    write_reg(REG_HEIGHT, 1023); write_reg(REG_WIDTH, 1023);
    queue_compute(510, 510); queue_compute(511, 100); queue_compute(5, 5);
    drain();
    write_reg(REG_HEIGHT, 1); write_reg(REG_WIDTH, 0);
    queue_compute(5, 5);
    drain();
    write_reg(REG_HEIGHT, 2); write_reg(REG_WIDTH, 2);
    queue_compute(0, 0); queue_compute(1, 1);
    drain();

    // Random phases with rotations and fractional offsets kept in the patch
    for (int ph = 0; ph < 8; ph++) begin
      int n;
      case (ph)
        0: begin write_reg(REG_COS, 20'h04000); write_reg(REG_SIN, 20'h0); end
        1: begin write_reg(REG_COS, 20'h0); write_reg(REG_SIN, 20'h04000); end
        2: begin write_reg(REG_COS, 20'h0C000); write_reg(REG_SIN, 20'h0); end
        3: begin write_reg(REG_COS, 20'h0); write_reg(REG_SIN, 20'h0C000); end
        default: begin
          write_reg(REG_COS, $urandom_range(0, 16384) - 8192);
          write_reg(REG_SIN, $urandom_range(0, 16384) - 8192);
        end
      endcase
      write_reg(REG_OFF_R, (ph == 4) ? 20'h40000 : (ph == 5) ? 20'hC0000 :
                $urandom_range(0, 6000) - 3000);
      write_reg(REG_OFF_C, $urandom_range(0, 6000) - 3000);
      write_reg(REG_HEIGHT, (ph == 6) ? 512 : $urandom_range(2, 16));
      write_reg(REG_WIDTH, (ph == 6) ? 512 : $urandom_range(2, 16));
      n = 0;
      while (n < 35) begin
        int sz;
        sz = pending_beats.size();
        if ($urandom_range(0, 5) == 0) queue_load($urandom_range(0, 15), $urandom_range(0, 15));
        else if ($urandom_range(0, 7) == 0) queue_compute($urandom, $urandom);
        else queue_compute($urandom_range(0, 24), $urandom_range(0, 24));
        if (pending_beats.size() > sz) n++;
      end
      // Long receiver hold-off once, sender pause before the next phase
      if (ph == 2) rx_hold_left = 200;
      drain();
    end

    bench_done = 1;
    if (errors == 0) $display("tb_image_rotate_backward_bilinear: PASS");
    else $display("tb_image_rotate_backward_bilinear: FAIL");
    $finish;
  end

endmodule
